// ----- rtl/dem_pkg.sv -----
// Shared types and constants of the decimal exponent modular power unit.
// Holds the controller states, datapath command and status structs and field widths.
// Depends on nothing.
`default_nettype none

package dem_pkg;

   localparam int ResidueWidth = 16;
   localparam int BaseWidth    = 31;
   localparam int DigitWidth   = 4;
   localparam int ProdWidth    = 32;
   localparam int RemWidth     = 17;
   localparam int RecipSteps   = 32;
   localparam int CountWidth   = 6;
   localparam int StepWidth    = 2;

   localparam logic [ResidueWidth-1:0] ModulusReset = 16'd1337;
   localparam logic [DigitWidth-1:0]   DigitRadix   = 4'd10;
   localparam logic [StepWidth-1:0]    LastStep     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_RED,
      ST_MUL,
      ST_SQR,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      A_RR,
      A_RB,
      A_SQ,
      A_ACC,
      A_HI,
      A_BASE
   } a_sel_type;

   typedef enum logic [1:0] {
      B_ONE,
      B_SQ,
      B_ACC
   } b_sel_type;

   typedef enum logic [1:0] {
      DST_RR,
      DST_RB,
      DST_SQ,
      DST_ACC
   } dst_type;

   typedef struct packed {
      logic      accept;
      logic      start;
      a_sel_type a_sel;
      b_sel_type b_sel;
      dst_type   dst;
      logic      acc_init;
      logic      hi_save;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic                  first;
      logic [DigitWidth-1:0] digit;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/dem_recip.sv -----
// Reciprocal unit: computes floor(2^32 / modulus) one quotient bit per cycle.
// Restarts after reset and on every modulus write; uses dem_pkg constants.
`default_nettype none

module dem_recip (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [dem_pkg::ResidueWidth-1:0]    modulus,
   output logic      [dem_pkg::ProdWidth-1:0]       mu,
   output logic                                     busy
);

   logic [dem_pkg::CountWidth-1:0]   count_ff, count_in;
   logic [dem_pkg::ResidueWidth-1:0] rem_ff, rem_in;
   logic [dem_pkg::ProdWidth-1:0]    quot_ff, quot_in;
   logic [dem_pkg::RemWidth-1:0]     rem_shift;
   logic [dem_pkg::RemWidth-1:0]     rem_sub;
   logic                             take;

   assign busy = (count_ff != '0);
   assign mu   = quot_ff;

   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      rem_sub   = rem_shift - {1'b0, modulus};
      take      = (rem_shift >= {1'b0, modulus});
      count_in  = count_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      if (start) begin
         count_in = dem_pkg::CountWidth'(dem_pkg::RecipSteps);
         rem_in   = dem_pkg::ResidueWidth'(1);
      end else if (busy) begin
         count_in = count_ff - 1'b1;
         rem_in   = take ? rem_sub[dem_pkg::ResidueWidth-1:0]
                         : rem_shift[dem_pkg::ResidueWidth-1:0];
         quot_in  = {quot_ff[dem_pkg::ProdWidth-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= dem_pkg::CountWidth'(dem_pkg::RecipSteps);
         rem_ff   <= dem_pkg::ResidueWidth'(1);
      end else begin
         count_ff <= count_in;
         rem_ff   <= rem_in;
      end
      quot_ff <= quot_in;
   end

endmodule

`default_nettype wire

// ----- rtl/dem_datapath.sv -----
// Datapath: operand registers, a three-stage Barrett modular multiplier and the result register.
// Driven by dem_ctrl through the command struct; uses dem_pkg types.
`default_nettype none

module dem_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dem_pkg::dp_cmd_type                 cmd,
   output dem_pkg::dp_status_type                   status,
   input  wire logic [dem_pkg::ResidueWidth-1:0]    modulus,
   input  wire logic [dem_pkg::ProdWidth-1:0]       mu,
   input  wire logic [dem_pkg::BaseWidth-1:0]       req_base,
   input  wire logic [dem_pkg::DigitWidth-1:0]      req_digit,
   input  wire logic                                req_first,
   input  wire logic                                req_last,
   output logic      [dem_pkg::ResidueWidth-1:0]    rsp_residue,
   output logic                                     rsp_done_res
);

   localparam int W = dem_pkg::ResidueWidth;
   localparam int P = dem_pkg::ProdWidth;

   logic [dem_pkg::BaseWidth-1:0]  base_ff;
   logic [dem_pkg::DigitWidth-1:0] digit_ff;
   logic                           first_ff;
   logic                           last_ff;
   logic [W-1:0]                   rr_ff, rb_ff, sq_ff, acc_ff, hi_ff;
   logic [W-1:0]                   rsp_residue_ff;
   logic                           rsp_done_ff;
   logic                           v1_ff, v2_ff, v3_ff;
   logic [P-1:0]                   p_ff, p2_ff, q_ff;
   logic [dem_pkg::RemWidth-1:0]   r_ff;
   dem_pkg::dst_type               dst_ff;

   logic [W-1:0]                   a_val, b_val;
   logic [P-1:0]                   prod, p_in;
   logic [2*P-1:0]                 mu_prod;
   logic [P+W-1:0]                 qm;
   logic [P-1:0]                   r_wide;
   logic [dem_pkg::RemWidth-1:0]   r_sub;
   logic                           small_mod;
   logic [W-1:0]                   one_mod;
   logic [W-1:0]                   res;

   assign small_mod = (modulus[W-1:1] == '0);
   assign one_mod   = {{(W-1){1'b0}}, ~small_mod};

   always_comb begin
      unique case (cmd.a_sel)
         dem_pkg::A_RR:  a_val = rr_ff;
         dem_pkg::A_RB:  a_val = rb_ff;
         dem_pkg::A_SQ:  a_val = sq_ff;
         dem_pkg::A_ACC: a_val = acc_ff;
         dem_pkg::A_HI:  a_val = hi_ff;
         default:        a_val = '0;
      endcase
      unique case (cmd.b_sel)
         dem_pkg::B_ONE: b_val = W'(1);
         dem_pkg::B_SQ:  b_val = sq_ff;
         dem_pkg::B_ACC: b_val = acc_ff;
         default:        b_val = '0;
      endcase
      prod = a_val * b_val;
      p_in = (cmd.a_sel == dem_pkg::A_BASE) ? {1'b0, base_ff} : prod;
   end

   always_comb begin
      mu_prod = p_ff * mu;
      qm      = q_ff * {{P{1'b0}}, modulus};
      r_wide  = p2_ff - qm[P-1:0];
      r_sub   = r_ff - {1'b0, modulus};
      if (small_mod) begin
         res = '0;
      end else if (r_ff >= {1'b0, modulus}) begin
         res = r_sub[W-1:0];
      end else begin
         res = r_ff[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rr_ff <= W'(1);
         rb_ff <= '0;
      end else begin
         v1_ff <= cmd.start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (cmd.accept && req_first) begin
            rr_ff <= W'(1);
         end else if (v3_ff && dst_ff == dem_pkg::DST_RR) begin
            rr_ff <= res;
         end
         if (v3_ff && dst_ff == dem_pkg::DST_RB) begin
            rb_ff <= res;
         end
      end
      if (cmd.accept) begin
         base_ff  <= req_base;
         digit_ff <= req_digit;
         first_ff <= req_first;
         last_ff  <= req_last;
      end
      if (cmd.start) begin
         p_ff   <= p_in;
         dst_ff <= cmd.dst;
      end
      p2_ff <= p_ff;
      q_ff  <= mu_prod[2*P-1:P];
      r_ff  <= r_wide[dem_pkg::RemWidth-1:0];
      if (cmd.hi_save) begin
         hi_ff <= acc_ff;
      end
      if (cmd.acc_init) begin
         acc_ff <= one_mod;
      end else if (v3_ff && dst_ff == dem_pkg::DST_ACC) begin
         acc_ff <= res;
      end
      if (v3_ff && dst_ff == dem_pkg::DST_SQ) begin
         sq_ff <= res;
      end
      if (cmd.load_rsp) begin
         rsp_residue_ff <= rr_ff;
         rsp_done_ff    <= last_ff;
      end
   end

   assign status.busy  = v1_ff | v2_ff | v3_ff;
   assign status.done  = v3_ff;
   assign status.first = first_ff;
   assign status.digit = digit_ff;

   assign rsp_residue  = rsp_residue_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

`default_nettype wire

// ----- rtl/dem_ctrl.sv -----
// Controller: sequences the square-and-multiply steps of each digit on the shared multiplier.
// Commands dem_datapath and owns the handshake state; uses dem_pkg types.
`default_nettype none

module dem_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic                    recip_busy,
   input  wire dem_pkg::dp_status_type  status,
   output dem_pkg::dp_cmd_type          cmd
);

   dem_pkg::state_type                state_ff, state_in;
   logic [dem_pkg::StepWidth-1:0]     step_ff, step_in;
   logic                              phase_hi_ff, phase_hi_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dem_pkg::DigitWidth-1:0]    expo;
   logic                              expo_bit;
   logic                              slot_free;

   assign expo      = phase_hi_ff ? dem_pkg::DigitRadix : status.digit;
   assign expo_bit  = expo[step_ff];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == dem_pkg::ST_IDLE) && !recip_busy;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      phase_hi_in = phase_hi_ff;
      unique case (state_ff)
         dem_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in    = dem_pkg::ST_BASE;
               phase_hi_in = 1'b1;
            end
         end
         dem_pkg::ST_BASE: begin
            if (!status.first || status.done) begin
               state_in = dem_pkg::ST_RED;
            end
         end
         dem_pkg::ST_RED: begin
            if (status.done) begin
               state_in = dem_pkg::ST_MUL;
               step_in  = '0;
            end
         end
         dem_pkg::ST_MUL: begin
            if (!expo_bit || status.done) begin
               if (step_ff != dem_pkg::LastStep) begin
                  state_in = dem_pkg::ST_SQR;
               end else if (phase_hi_ff) begin
                  state_in    = dem_pkg::ST_RED;
                  phase_hi_in = 1'b0;
               end else begin
                  state_in = dem_pkg::ST_FIN;
               end
            end
         end
         dem_pkg::ST_SQR: begin
            if (status.done) begin
               state_in = dem_pkg::ST_MUL;
               step_in  = step_ff + 1'b1;
            end
         end
         dem_pkg::ST_FIN: begin
            if (status.done) begin
               state_in = dem_pkg::ST_OUT;
            end
         end
         dem_pkg::ST_OUT: begin
            if (slot_free) begin
               state_in = dem_pkg::ST_IDLE;
            end
         end
         default: state_in = dem_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.a_sel    = dem_pkg::A_SQ;
      cmd.b_sel    = dem_pkg::B_SQ;
      cmd.dst      = dem_pkg::DST_SQ;
      cmd.accept   = req_valid && req_ready;
      unique case (state_ff)
         dem_pkg::ST_BASE: begin
            cmd.start = status.first && !status.busy;
            cmd.a_sel = dem_pkg::A_BASE;
            cmd.b_sel = dem_pkg::B_ONE;
            cmd.dst   = dem_pkg::DST_RB;
         end
         dem_pkg::ST_RED: begin
            cmd.start    = !status.busy;
            cmd.a_sel    = phase_hi_ff ? dem_pkg::A_RR : dem_pkg::A_RB;
            cmd.b_sel    = dem_pkg::B_ONE;
            cmd.dst      = dem_pkg::DST_SQ;
            cmd.acc_init = !status.busy;
            cmd.hi_save  = !status.busy && !phase_hi_ff;
         end
         dem_pkg::ST_MUL: begin
            cmd.start = expo_bit && !status.busy;
            cmd.a_sel = dem_pkg::A_ACC;
            cmd.b_sel = dem_pkg::B_SQ;
            cmd.dst   = dem_pkg::DST_ACC;
         end
         dem_pkg::ST_SQR: begin
            cmd.start = !status.busy;
         end
         dem_pkg::ST_FIN: begin
            cmd.start = !status.busy;
            cmd.a_sel = dem_pkg::A_HI;
            cmd.b_sel = dem_pkg::B_ACC;
            cmd.dst   = dem_pkg::DST_RR;
         end
         dem_pkg::ST_OUT: begin
            cmd.load_rsp = slot_free;
         end
         default: cmd.start = 1'b0;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dem_pkg::ST_IDLE;
         step_ff      <= '0;
         phase_hi_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_hi_ff  <= phase_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/decimal_exponent_modpow_unit.sv -----
// Each accepted beat runs the square-and-multiply steps of its digit on the shared multiplier,
// with a base reduction first when first is set. One item is worked at a time: a new beat is
// taken only once the last is through, and a finished result waits in the output register.
// Reset: synchronous; residue 1, reduced base 0, modulus 1337. The reciprocal of the modulus is
// rebuilt after reset and after each modulus write, with req_ready low meanwhile.
`default_nettype none

module decimal_exponent_modpow_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [dem_pkg::BaseWidth-1:0]       req_base,
   input  wire logic [dem_pkg::DigitWidth-1:0]      req_digit,
   input  wire logic                                req_first,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [dem_pkg::ResidueWidth-1:0]    rsp_residue,
   output logic                                     rsp_done_res,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dem_pkg::ResidueWidth-1:0]    csr_data
);

   logic [dem_pkg::ResidueWidth-1:0] modulus_ff;
   logic [dem_pkg::ProdWidth-1:0]    mu;
   logic                             recip_busy;
   logic                             csr_write;
   dem_pkg::dp_cmd_type              cmd;
   dem_pkg::dp_status_type           status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= dem_pkg::ModulusReset;
      end else if (csr_write) begin
         modulus_ff <= csr_data;
      end
   end

   dem_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_write),
      .modulus (modulus_ff),
      .mu      (mu),
      .busy    (recip_busy)
   );

   dem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .recip_busy (recip_busy),
      .status     (status),
      .cmd        (cmd)
   );

   dem_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .modulus      (modulus_ff),
      .mu           (mu),
      .req_base     (req_base),
      .req_digit    (req_digit),
      .req_first    (req_first),
      .req_last     (req_last),
      .rsp_residue  (rsp_residue),
      .rsp_done_res (rsp_done_res)
   );

endmodule

`default_nettype wire

// ----- rtl/dem_checker.sv -----
// Port-level checker for the decimal exponent modular power unit, bound to the top level.
// Depends on dem_pkg widths and on the top level's port names.
`default_nettype none

module dem_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [dem_pkg::ResidueWidth-1:0]    rsp_residue,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready
);

   // A result beat that is not taken stays offered with the same residue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_residue))
      else $error("result beat dropped or changed while stalled");

   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready or offering a result right after reset");

   // One item is worked at a time, so an accepted beat closes the input side.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   // A modulus write starts a new reciprocal, which holds off input beats.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("input ready while the reciprocal is rebuilt");

endmodule

bind decimal_exponent_modpow_unit dem_checker u_dem_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_residue (rsp_residue),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);

`default_nettype wire

// ----- test/decimal_exponent_modpow_unit_tb.sv -----
// Self-checking testbench for decimal_exponent_modpow_unit: a directed table followed by random
// digit sequences under several moduli, with random idling on both channels and one long stall.
// Depends on dem_pkg and the unit; results are checked by an in-bench predictor or table rows.
`timescale 1ns / 100ps

module decimal_exponent_modpow_unit_tb;

   localparam int WatchdogLimit = 5000;
   localparam int HoldCycles    = 400;
   localparam int HoldAfter     = 330;
   localparam int TailCycles    = 120;
   localparam int DirectedRows  = 25;

   typedef logic [dem_pkg::BaseWidth-1:0]    base_type;
   typedef logic [dem_pkg::DigitWidth-1:0]   digit_type;
   typedef logic [dem_pkg::ResidueWidth-1:0] residue_type;

   typedef struct packed {
      residue_type residue;
      logic        done_res;
   } residue_beat_type;

   typedef struct packed {
      base_type    base;
      digit_type   digit;
      logic        first;
      logic        last;
      logic        known;
      residue_type residue;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   base_type    req_base = '0;
   digit_type   req_digit = '0;
   logic        req_first = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   residue_type rsp_residue;
   logic        rsp_done_res;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   residue_type csr_data = '0;

   logic        row_known = 1'b0;
   residue_type row_residue = '0;

   residue_type      model_modulus = dem_pkg::ModulusReset;
   residue_type      model_residue = 16'd1;
   residue_type      model_base = '0;
   residue_beat_type pending_residues[$];
   int               failures = 0;
   int               beats_accepted = 0;
   int               quiet_cycles = 0;
   logic             steady = 1'b0;
   residue_type      modulus_setting = dem_pkg::ModulusReset;

   directed_row_type directed_rows [0:DirectedRows-1] = '{
      '{31'd5,          4'd0,  1'b0, 1'b0, 1'b1, 16'd1},
      '{31'd7,          4'd3,  1'b0, 1'b1, 1'b1, 16'd0},
      '{31'd0,          4'd0,  1'b1, 1'b1, 1'b1, 16'd1},
      '{31'd0,          4'd9,  1'b1, 1'b1, 1'b1, 16'd0},
      '{31'd1,          4'd15, 1'b1, 1'b1, 1'b1, 16'd1},
      '{31'd1337,       4'd5,  1'b1, 1'b1, 1'b1, 16'd0},
      '{31'd2,          4'd1,  1'b1, 1'b0, 1'b1, 16'd2},
      '{31'd0,          4'd0,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd3,          4'd1,  1'b1, 1'b0, 1'b0, 16'd0},
      '{31'h7FFF_FFFF,  4'd2,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'h5555_5555,  4'd3,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'h2AAA_AAAA,  4'd4,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd0,          4'd5,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd9,          4'd6,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd9,          4'd7,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd9,          4'd8,  1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd9,          4'd9,  1'b0, 1'b1, 1'b0, 16'd0},
      '{31'h7FFF_FFFF,  4'd10, 1'b1, 1'b0, 1'b0, 16'd0},
      '{31'h2AAA_AAAA,  4'd11, 1'b0, 1'b0, 1'b0, 16'd0},
      '{31'h5555_5555,  4'd12, 1'b0, 1'b0, 1'b0, 16'd0},
      '{31'h7FFF_FFFF,  4'd13, 1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd0,          4'd14, 1'b0, 1'b0, 1'b0, 16'd0},
      '{31'd0,          4'd15, 1'b0, 1'b1, 1'b0, 16'd0},
      '{31'd2674,       4'd0,  1'b1, 1'b1, 1'b1, 16'd1},
      '{31'd1338,       4'd7,  1'b1, 1'b1, 1'b1, 16'd1}
   };

   decimal_exponent_modpow_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_base     (req_base),
      .req_digit    (req_digit),
      .req_first    (req_first),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_residue  (rsp_residue),
      .rsp_done_res (rsp_done_res),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] reduce_mod(logic [63:0] value);
      if (model_modulus == '0) begin
         return 64'd0;
      end
      return value % {48'd0, model_modulus};
   endfunction

   // Square-and-multiply over the four bits of the exponent.
   function automatic logic [63:0] power_mod(logic [63:0] x, digit_type e);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = reduce_mod(64'd1);
      sq = reduce_mod(x);
      for (int k = 0; k < dem_pkg::DigitWidth; k++) begin
         if (e[k]) begin
            acc = reduce_mod(acc * sq);
         end
         sq = reduce_mod(sq * sq);
      end
      return acc;
   endfunction

   function automatic residue_type predict_residue(base_type b, digit_type d, logic f);
      logic [63:0] hi;
      logic [63:0] lo;
      if (f) begin
         model_residue = 16'd1;
         model_base = residue_type'(reduce_mod({33'd0, b}));
      end
      hi = power_mod({48'd0, model_residue}, dem_pkg::DigitRadix);
      lo = power_mod({48'd0, model_base}, d);
      model_residue = residue_type'(reduce_mod(hi * lo));
      return model_residue;
   endfunction

   always @(posedge clock) begin
      residue_beat_type expected;
      residue_type predicted;
      if (reset) begin
         model_modulus = dem_pkg::ModulusReset;
         model_residue = 16'd1;
         model_base = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            model_modulus = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_residues.size() == 0) begin
               $error("unexpected rsp beat: residue %0d done_res %0b", rsp_residue,
                      rsp_done_res);
               failures++;
            end else begin
               expected = pending_residues.pop_front();
               if (rsp_residue !== expected.residue) begin
                  $error("residue: expected %0d, actual %0d", expected.residue, rsp_residue);
                  failures++;
               end
               if (rsp_done_res !== expected.done_res) begin
                  $error("done_res: expected %0b, actual %0b", expected.done_res,
                         rsp_done_res);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = predict_residue(req_base, req_digit, req_first);
            pending_residues.push_back('{row_known ? row_residue : predicted, req_last});
            beats_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && beats_accepted >= HoldAfter) begin
            rsp_ready <= 1'b0;
            hold_left = HoldCycles - 1;
            hold_done = 1'b1;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 24);
         end
      end
   end

   function automatic base_type pick_base();
      case ($urandom_range(3))
         0: return base_type'($urandom_range(40));
         1: return base_type'($urandom_range(65535));
         2: return base_type'(modulus_setting * $urandom_range(1, 3) + $urandom_range(2));
         default: return base_type'($urandom());
      endcase
   endfunction

   function automatic digit_type pick_digit();
      if ($urandom_range(99) < 80) begin
         return digit_type'($urandom_range(9));
      end
      return digit_type'($urandom_range(15, 10));
   endfunction

   task automatic send_digit(input base_type b, input digit_type d, input logic f,
                             input logic l, input logic known, input residue_type r);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_base <= b;
      req_digit <= d;
      req_first <= f;
      req_last <= l;
      row_known <= known;
      row_residue <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_modulus(input residue_type value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_residues.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      residue_type extremes [0:3];
      int remaining;
      int len;
      logic carry;
      logic broken;
      logic f;
      logic l;
      extremes = '{16'd0, 16'd1, 16'd2, 16'hFFFF};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirectedRows; i++) begin
         send_digit(directed_rows[i].base, directed_rows[i].digit, directed_rows[i].first,
                    directed_rows[i].last, directed_rows[i].known, directed_rows[i].residue);
      end
      req_valid <= 1'b0;
      row_known <= 1'b0;

      for (int p = 0; p < 9; p++) begin
         wait_drained();
         if (p < 4) begin
            modulus_setting = extremes[p];
         end else if (p == 8) begin
            modulus_setting = dem_pkg::ModulusReset;
         end else begin
            modulus_setting = residue_type'($urandom_range(65535, 2));
         end
         write_modulus(modulus_setting);
         steady = (p == 5);
         remaining = (p < 2) ? 40 : 135;
         carry = 1'($urandom_range(1));
         while (remaining > 0) begin
            len = $urandom_range(8, 1);
            if (len > remaining) begin
               len = remaining;
            end
            broken = ($urandom_range(99) < 15);
            for (int k = 0; k < len; k++) begin
               if (broken) begin
                  f = 1'($urandom_range(1));
                  l = 1'($urandom_range(1));
               end else begin
                  f = (k == 0) && !carry;
                  l = (k == len - 1);
               end
               send_digit(pick_base(), pick_digit(), f, l, 1'b0, '0);
            end
            carry = 1'b0;
            remaining -= len;
         end
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (TailCycles) @(negedge clock);
      if (failures == 0 && pending_residues.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
